// ===== rtl/core/pse_pkg.sv =====
`default_nettype none
package pse_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 48;
  localparam int SUM_W     = 52;
  localparam int OCC_W     = 17;
  localparam int BROAD_W   = 31;
  localparam int CFG_IDX_W = 2;

  // Occupation of exactly one in unsigned Q1.16.
  localparam logic [OCC_W-1:0] OCC_ONE = 17'h10000;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Symmetric saturation limit used by sat_q and the divider overflow.
  localparam q_t LIM = 32'sh7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ  = 2'd0,
    CFG_BROAD = 2'd1,
    CFG_OCC   = 2'd2,
    CFG_PREF  = 2'd3
  } cfg_idx_t;

  // One pole after the front end: both denominators already formed and
  // saturated, the clamped occupation and the flags for skipped terms.
  typedef struct packed {
    q_t               xr;
    q_t               xi;
    q_t               yr;
    q_t               yi;
    q_t               wr;
    q_t               wi;
    logic [OCC_W-1:0] occ;
    logic             skip_a;
    logic             skip_b;
    logic             last;
  } pole_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM,
    ST_NORM,
    ST_DIV,
    ST_MIX,
    ST_RES,
    ST_SCALE,
    ST_OUT
  } back_state_t;

  function automatic q_t sat_q(input sum_t v);
    if (v > sum_t'(LIM)) begin
      return LIM;
    end else if (v < -sum_t'(LIM)) begin
      return -LIM;
    end
    return q_t'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pse_if.sv =====
`default_nettype none
interface pse_in_if import pse_pkg::*; ();
  logic valid;
  logic ready;
  q_t   pole_pos_re;
  q_t   pole_pos_im;
  q_t   residue_re;
  q_t   residue_im;
  logic last_pole;

  modport source (output valid, pole_pos_re, pole_pos_im, residue_re, residue_im, last_pole,
                  input ready);
  modport sink (input valid, pole_pos_re, pole_pos_im, residue_re, residue_im, last_pole,
                output ready);
endinterface

interface pse_out_if import pse_pkg::*; ();
  logic valid;
  logic ready;
  q_t   value_re;
  q_t   value_im;
  q_t   deriv_re;
  q_t   deriv_im;

  modport source (output valid, value_re, value_im, deriv_re, deriv_im, input ready);
  modport sink (input valid, value_re, value_im, deriv_re, deriv_im, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pse_front.sv =====
`default_nettype none
module pse_front import pse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  pse_in_if.sink             in_ch,
  input  q_t                 freq,
  input  logic [BROAD_W-1:0] broad,
  input  logic [OCC_W-1:0]   occ,
  output logic               q_valid,
  input  logic               q_ready,
  output pole_item_t         q_item
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pole_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;
  logic [OCC_W-1:0] occ_clamped;
  pole_item_t       item_new;

  // Form both denominators and decide which terms carry any weight.
  always_comb begin
    occ_clamped     = (occ > OCC_ONE) ? OCC_ONE : occ;
    item_new.xr     = sat_q(sum_t'(freq) + sum_t'(in_ch.pole_pos_re));
    item_new.xi     = sat_q(sum_t'(in_ch.pole_pos_im) - sum_t'(broad));
    item_new.yr     = sat_q(sum_t'(freq) - sum_t'(in_ch.pole_pos_re));
    item_new.yi     = sat_q(sum_t'(broad) - sum_t'(in_ch.pole_pos_im));
    item_new.wr     = in_ch.residue_re;
    item_new.wi     = in_ch.residue_im;
    item_new.occ    = occ_clamped;
    item_new.skip_a = (occ_clamped == '0);
    item_new.skip_b = (occ_clamped == OCC_ONE);
    item_new.last   = in_ch.last_pole;
  end

  assign in_ch.ready = (cnt_r != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_new;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pse_back.sv =====
`default_nettype none
module pse_back import pse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  pole_item_t q_item,
  input  q_t         pref,
  pse_out_if.source  out_ch
);

  localparam int STEP_W = 4;
  localparam int CNT_W  = 6;
  localparam int LANES  = 2;
  localparam int NUM_W  = 48;
  localparam int DVD_SH = 2 * FRAC_BITS - 16;
  localparam int SC_SH  = FRAC_BITS - 1;
  localparam int SC_W   = 50;
  localparam logic [CNT_W-1:0]  DIV_TOP    = 6'd62;
  localparam logic [CNT_W-1:0]  DIV_SAT    = 6'd31;
  localparam logic [STEP_W-1:0] NORM_LAST  = 4'd4;
  localparam logic [STEP_W-1:0] MIX_LAST   = 4'd7;
  localparam logic [STEP_W-1:0] RES_LAST   = 4'd9;
  localparam logic [STEP_W-1:0] SCALE_LAST = 4'd8;
  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic signed [SUM_W:0] wide_t;

  function automatic logic [DATA_W-1:0] mag_q(input q_t x);
    logic [DATA_W-1:0] u;
    u = x;
    return x[DATA_W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic [ACC_W-1:0] mag_acc(input acc_t x);
    logic [ACC_W-1:0] u;
    u = x;
    return x[ACC_W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic acc_t acc_add(input acc_t a, input sum_t d);
    wide_t s;
    s = wide_t'(a) + wide_t'(d);
    if (s > wide_t'(ACC_MAX)) begin
      return ACC_MAX;
    end else if (s < wide_t'(ACC_MIN)) begin
      return ACC_MIN;
    end
    return acc_t'(s);
  endfunction

  back_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt, step_m1;
  logic [CNT_W-1:0]  div_cnt_r;
  logic              term_r;
  pole_item_t        item_r;
  logic [63:0]       prod_r;
  logic              pneg_r;
  logic [31:0]       mul_a, mul_b;
  logic              mul_neg;
  logic [63:0]       den_r;
  logic [NUM_W-1:0]  dnum_r [LANES];
  logic [LANES-1:0]  nneg_r;
  logic [63:0]       rem_r [LANES];
  logic [30:0]       quo_r [LANES];
  logic [LANES-1:0]  ovf_r;
  logic [63:0]       dvd [LANES];
  logic [63:0]       rem_sh [LANES];
  logic [63:0]       rem_nx [LANES];
  logic [LANES-1:0]  qbit;
  logic [30:0]       quo_fin [LANES];
  q_t                qmag [LANES];
  q_t                div_res [LANES];
  q_t                ar_r, ai_r, br_r, bi_r;
  q_t                sr_r, si_r, qr_r, qi_r;
  sum_t              sum_r [4];
  acc_t              acc_r [4];
  q_t                res_r [4];
  q_t                out_r [4];
  logic [SC_W-2:0]   lo_r;
  logic              out_valid_r;
  logic              out_free;
  q_t                cr, ci;
  logic              ni_neg;
  logic [OCC_W-1:0]  occ_t;
  logic              term_skip;
  sum_t              t_val;
  logic [1:0]        issue_idx;
  logic [ACC_W-1:0]  scale_mag;
  logic              sc_ovf;
  logic [SC_W-1:0]   sc_r, sc_cap, sc_sel;
  q_t                sc_res;

  // Operands of the term in progress: term a uses omega + pos - i*eta,
  // term b uses omega - pos + i*eta; the numerator is the conjugate.
  always_comb begin
    cr        = term_r ? item_r.yr : item_r.xr;
    ci        = term_r ? item_r.yi : item_r.xi;
    ni_neg    = !ci[DATA_W-1] && (ci != '0);
    occ_t     = term_r ? (OCC_ONE - item_r.occ) : item_r.occ;
    term_skip = term_r ? item_r.skip_b : item_r.skip_a;
    out_free  = !out_valid_r || out_ch.ready;
    step_m1   = step_r - 1'b1;
    t_val     = sum_t'({1'b0, prod_r[63:FRAC_BITS]});
    if (pneg_r) begin
      t_val = -t_val;
    end
  end

  // Restoring division, two lanes sharing one denominator.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dvd[l]     = {dnum_r[l], {DVD_SH{1'b0}}};
      rem_sh[l]  = {rem_r[l][62:0], dvd[l][div_cnt_r]};
      qbit[l]    = (rem_sh[l] >= den_r);
      rem_nx[l]  = qbit[l] ? (rem_sh[l] - den_r) : rem_sh[l];
      quo_fin[l] = {quo_r[l][29:0], qbit[l]};
      qmag[l]    = ovf_r[l] ? LIM : q_t'({1'b0, quo_fin[l]});
      if (den_r == '0) begin
        div_res[l] = '0;
      end else begin
        div_res[l] = nneg_r[l] ? -qmag[l] : qmag[l];
      end
    end
  end

  // Output scaling: acc * 2 * prefactor from two partial products.
  always_comb begin
    sc_ovf = |prod_r[63:SC_SH];
    sc_r   = SC_W'({prod_r[SC_SH-1:0], {(32-SC_SH){1'b0}}}) + SC_W'(lo_r);
    sc_cap = pneg_r ? SC_W'(33'h0_8000_0000) : SC_W'(33'h0_7FFF_FFFF);
    sc_sel = (sc_ovf || (sc_r > sc_cap)) ? sc_cap : sc_r;
    sc_res = pneg_r ? q_t'(-sc_sel[31:0]) : q_t'(sc_sel[31:0]);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        if (!term_skip) begin
          state_nxt = ST_NORM;
          step_nxt  = '0;
        end else if (term_r) begin
          state_nxt = ST_MIX;
          step_nxt  = '0;
        end
      end
      ST_NORM: begin
        if (step_r == NORM_LAST) begin
          state_nxt = ST_DIV;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == '0) begin
          step_nxt  = '0;
          state_nxt = term_r ? ST_MIX : ST_TERM;
        end
      end
      ST_MIX: begin
        if (step_r == MIX_LAST) begin
          state_nxt = ST_RES;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_RES: begin
        if (step_r == RES_LAST) begin
          state_nxt = item_r.last ? ST_SCALE : ST_IDLE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SCALE: begin
        if (step_r == SCALE_LAST) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: queue pop and the operands of the shared multiplier.
  always_comb begin
    q_ready   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_neg   = 1'b0;
    issue_idx = step_r[2:1];
    scale_mag = mag_acc(acc_r[issue_idx]);
    case (state_r)
      ST_IDLE: q_ready = 1'b1;
      ST_NORM: begin
        case (step_r)
          4'd0: begin mul_a = mag_q(cr); mul_b = mag_q(cr); end
          4'd1: begin mul_a = mag_q(ci); mul_b = mag_q(ci); end
          4'd2: begin mul_a = mag_q(cr); mul_b = 32'(occ_t); end
          4'd3: begin mul_a = mag_q(ci); mul_b = 32'(occ_t); end
          default: ;
        endcase
      end
      ST_MIX: begin
        case (step_r)
          4'd0: begin mul_a = mag_q(ar_r); mul_b = mag_q(ar_r); end
          4'd1: begin mul_a = mag_q(ai_r); mul_b = mag_q(ai_r); mul_neg = 1'b1; end
          4'd2: begin mul_a = mag_q(br_r); mul_b = mag_q(br_r); end
          4'd3: begin mul_a = mag_q(bi_r); mul_b = mag_q(bi_r); mul_neg = 1'b1; end
          4'd4: begin
            mul_a = mag_q(ar_r); mul_b = mag_q(ai_r); mul_neg = ar_r[31] ^ ai_r[31];
          end
          4'd5: begin
            mul_a = mag_q(br_r); mul_b = mag_q(bi_r); mul_neg = br_r[31] ^ bi_r[31];
          end
          default: ;
        endcase
      end
      ST_RES: begin
        // Products for v_re, v_im, -d_re, -d_im, two per sum.
        case (step_r)
          4'd0: begin
            mul_a = mag_q(sr_r); mul_b = mag_q(item_r.wr); mul_neg = sr_r[31] ^ item_r.wr[31];
          end
          4'd1: begin
            mul_a = mag_q(si_r); mul_b = mag_q(item_r.wi); mul_neg = ~(si_r[31] ^ item_r.wi[31]);
          end
          4'd2: begin
            mul_a = mag_q(sr_r); mul_b = mag_q(item_r.wi); mul_neg = sr_r[31] ^ item_r.wi[31];
          end
          4'd3: begin
            mul_a = mag_q(si_r); mul_b = mag_q(item_r.wr); mul_neg = si_r[31] ^ item_r.wr[31];
          end
          4'd4: begin
            mul_a = mag_q(qr_r); mul_b = mag_q(item_r.wr); mul_neg = ~(qr_r[31] ^ item_r.wr[31]);
          end
          4'd5: begin
            mul_a = mag_q(qi_r); mul_b = mag_q(item_r.wi); mul_neg = qi_r[31] ^ item_r.wi[31];
          end
          4'd6: begin
            mul_a = mag_q(qr_r); mul_b = mag_q(item_r.wi); mul_neg = ~(qr_r[31] ^ item_r.wi[31]);
          end
          4'd7: begin
            mul_a = mag_q(qi_r); mul_b = mag_q(item_r.wr); mul_neg = ~(qi_r[31] ^ item_r.wr[31]);
          end
          default: ;
        endcase
      end
      ST_SCALE: begin
        if (step_r < SCALE_LAST) begin
          mul_a   = step_r[0] ? 32'(scale_mag[ACC_W-1:32]) : scale_mag[31:0];
          mul_b   = mag_q(pref);
          mul_neg = acc_r[issue_idx][ACC_W-1] ^ pref[DATA_W-1];
        end
      end
      default: ;
    endcase
  end

  // Control registers and accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      term_r      <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (state_r == ST_IDLE) begin
        term_r <= 1'b0;
      end else if ((state_r == ST_TERM && term_skip) ||
                   (state_r == ST_DIV && div_cnt_r == '0)) begin
        term_r <= 1'b1;
      end
      if (state_r == ST_NORM) begin
        div_cnt_r <= DIV_TOP;
      end else if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      if (state_r == ST_RES && step_r == RES_LAST) begin
        for (int i = 0; i < 4; i++) begin
          acc_r[i] <= acc_add(acc_r[i], sum_r[i]);
        end
      end else if (state_r == ST_SCALE && step_r == SCALE_LAST) begin
        for (int i = 0; i < 4; i++) begin
          acc_r[i] <= '0;
        end
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    pneg_r <= mul_neg;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          item_r <= q_item;
        end
      end
      ST_TERM: begin
        if (term_skip) begin
          if (term_r) begin
            br_r <= '0;
            bi_r <= '0;
          end else begin
            ar_r <= '0;
            ai_r <= '0;
          end
        end
      end
      ST_NORM: begin
        case (step_r)
          4'd1: den_r <= prod_r;
          4'd2: den_r <= den_r + prod_r;
          4'd3: begin
            dnum_r[0] <= prod_r[NUM_W-1:0];
            nneg_r[0] <= cr[DATA_W-1];
          end
          4'd4: begin
            dnum_r[1] <= prod_r[NUM_W-1:0];
            nneg_r[1] <= ni_neg;
            for (int l = 0; l < LANES; l++) begin
              rem_r[l] <= '0;
              quo_r[l] <= '0;
              ovf_r[l] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[l] <= rem_nx[l];
          quo_r[l] <= quo_fin[l];
          if (qbit[l] && div_cnt_r >= DIV_SAT) begin
            ovf_r[l] <= 1'b1;
          end
        end
        if (div_cnt_r == '0) begin
          if (term_r) begin
            br_r <= div_res[0];
            bi_r <= div_res[1];
          end else begin
            ar_r <= div_res[0];
            ai_r <= div_res[1];
          end
        end
      end
      ST_MIX: begin
        case (step_r) inside
          4'd0: begin
            sr_r     <= sat_q(sum_t'(ar_r) + sum_t'(br_r));
            si_r     <= sat_q(sum_t'(ai_r) + sum_t'(bi_r));
            sum_r[0] <= '0;
            sum_r[1] <= '0;
          end
          [4'd1:4'd4]: sum_r[0] <= sum_r[0] + t_val;
          [4'd5:4'd6]: sum_r[1] <= sum_r[1] + (t_val <<< 1);
          4'd7: begin
            qr_r <= sat_q(sum_r[0]);
            qi_r <= sat_q(sum_r[1]);
          end
          default: ;
        endcase
      end
      ST_RES: begin
        if (step_r == '0) begin
          for (int i = 0; i < 4; i++) begin
            sum_r[i] <= '0;
          end
        end else if (step_r <= SCALE_LAST) begin
          sum_r[step_m1[2:1]] <= sum_r[step_m1[2:1]] + t_val;
        end
      end
      ST_SCALE: begin
        if (step_r != '0) begin
          if (!step_m1[0]) begin
            lo_r <= prod_r[63:SC_SH];
          end else begin
            res_r[step_m1[2:1]] <= sc_res;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          for (int i = 0; i < 4; i++) begin
            out_r[i] <= res_r[i];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.value_re = out_r[0];
  assign out_ch.value_im = out_r[1];
  assign out_ch.deriv_re = out_r[2];
  assign out_ch.deriv_im = out_r[3];

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && q_valid) |=> (state_r == ST_TERM))
    else $error("popped pole did not start a term");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= DIV_TOP))
    else $error("divider count out of range");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE && step_r == SCALE_LAST) |=>
      (acc_r[0] == '0 && acc_r[1] == '0 && acc_r[2] == '0 && acc_r[3] == '0))
    else $error("accumulators not cleared after a result");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result shown outside the output step");

endmodule
`default_nettype wire

// ===== rtl/core/pole_sum_evaluator.sv =====
`default_nettype none
// The back end works on one pole at a time and evaluates both terms, or only one
// when the occupation is exactly zero or one; a last pole adds the output scaling.
// The restoring divider, run once per evaluated term, dominates the time per pole.
// A two-beat queue lets new poles be accepted while the back end is busy.
// Reset (rst_n low, synchronous) clears the queue, the accumulators and the result valid.
module pole_sum_evaluator import pse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pse_in_if.sink               in_ch,
  pse_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  // Configuration registers. Prefactor resets to one in Q16.16.
  q_t                 freq_r;
  logic [BROAD_W-1:0] broad_r;
  logic [OCC_W-1:0]   occ_r;
  q_t                 pref_r;

  // Queue handshake between the front end and the back end.
  logic       q_valid;
  logic       q_ready;
  pole_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= '0;
      broad_r <= '0;
      occ_r   <= '0;
      pref_r  <= q_t'(1) <<< FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FREQ:  freq_r  <= q_t'(cfg_wdata);
        CFG_BROAD: broad_r <= cfg_wdata[BROAD_W-1:0];
        CFG_OCC:   occ_r   <= cfg_wdata[OCC_W-1:0];
        CFG_PREF:  pref_r  <= q_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // The front end forms both complex denominators as each beat arrives and
  // flags a term whose occupation weight is zero, so the back end can skip
  // its division altogether.
  pse_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .freq    (freq_r),
    .broad   (broad_r),
    .occ     (occ_r),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // The back end runs the division, squares, residue products, saturating
  // accumulation and final scaling; all products share one 32x32 multiplier.
  pse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .pref    (pref_r),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
